[design/cvkt_pkg.sv]
// Shared types, constants and saturation helpers for the Kalman tracker.
`timescale 1ns / 1ps

package cvkt_pkg;

    localparam int AXES          = 3;
    localparam int AX_W          = (AXES > 1) ? $clog2(AXES) : 1;
    localparam int FRAC_BITS_DEF = 16;
    localparam int WORD_W        = 32;
    localparam int OPW           = WORD_W + 2;
    localparam int DEN_W         = WORD_W + 1;
    localparam int ACC_W         = 64;
    localparam int CNT_W         = 16;
    localparam int CFG_IDX_W     = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_PROCESS_NOISE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MEASUREMENT_NOISE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_ERROR_COV = 2'd2;

    localparam logic [WORD_W-1:0] PROCESS_NOISE_RST     = 32'd655;
    localparam logic [WORD_W-1:0] MEASUREMENT_NOISE_RST = 32'd6554;
    localparam logic [WORD_W-1:0] INITIAL_ERROR_COV_RST = 32'd65536;

    typedef logic        [WORD_W-1:0] t_word;
    typedef logic signed [WORD_W-1:0] t_sword;
    typedef logic signed [WORD_W:0]   t_err;
    typedef logic signed [OPW-1:0]    t_opnd;
    typedef logic signed [ACC_W-1:0]  t_acc;

    localparam t_acc ACC_SMAX = 64'sh0000_0000_7FFF_FFFF;
    localparam t_acc ACC_SMIN = -64'sh0000_0000_8000_0000;
    localparam t_acc ACC_UMAX = 64'sh0000_0000_FFFF_FFFF;

    function automatic t_sword sat_s(input t_acc a);
        if (a > ACC_SMAX) begin
            return t_sword'(ACC_SMAX[WORD_W-1:0]);
        end else if (a < ACC_SMIN) begin
            return t_sword'(ACC_SMIN[WORD_W-1:0]);
        end
        return t_sword'(a[WORD_W-1:0]);
    endfunction

    function automatic t_word sat_u(input t_acc a);
        if (a < 0) begin
            return '0;
        end else if (a > ACC_UMAX) begin
            return '1;
        end
        return a[WORD_W-1:0];
    endfunction

    function automatic t_acc acc_u(input t_word u);
        return t_acc'({{(ACC_W-WORD_W){1'b0}}, u});
    endfunction

    function automatic t_acc acc_s(input t_sword s);
        return t_acc'({{(ACC_W-WORD_W){s[WORD_W-1]}}, s});
    endfunction

    function automatic t_opnd op_u(input t_word u);
        return t_opnd'({2'b00, u});
    endfunction

    function automatic t_opnd op_s(input t_sword s);
        return t_opnd'({{2{s[WORD_W-1]}}, s});
    endfunction

    function automatic t_opnd op_e(input t_err e);
        return t_opnd'({e[WORD_W], e});
    endfunction

endpackage

[design/cvkt_meas_if.sv]
// Measurement channel: valid/ready handshake with xyz position and timestamp.
`timescale 1ns / 1ps

interface cvkt_meas_if import cvkt_pkg::*; ();
    logic   valid;
    logic   ready;
    t_sword meas_x;
    t_sword meas_y;
    t_sword meas_z;
    t_word  timestamp;

    modport source (output valid, meas_x, meas_y, meas_z, timestamp, input ready);
    modport sink   (input valid, meas_x, meas_y, meas_z, timestamp, output ready);
endinterface

[design/cvkt_est_if.sv]
// Estimate channel: valid/ready handshake with filtered position and count.
`timescale 1ns / 1ps

interface cvkt_est_if import cvkt_pkg::*; ();
    logic             valid;
    logic             ready;
    t_sword           est_x;
    t_sword           est_y;
    t_sword           est_z;
    logic [CNT_W-1:0] detection_count;

    modport source (output valid, est_x, est_y, est_z, detection_count, input ready);
    modport sink   (input valid, est_x, est_y, est_z, detection_count, output ready);
endinterface

[design/cvkt_mul.sv]
// Shared signed fixed-point multiplier, product registered, truncated toward zero.
`timescale 1ns / 1ps

module cvkt_mul import cvkt_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  t_opnd                         i_a,
    input  t_opnd                         i_b,
    output logic signed [64-FRAC_BITS:0]  o_res
);

    localparam int PW = 65 - FRAC_BITS;

    t_word                 a_mag;
    t_word                 b_mag;
    logic [2*WORD_W-1:0]   r_prod;
    logic                  r_neg;
    logic signed [PW-1:0]  res_pos;

    assign a_mag = i_a[OPW-1] ? t_word'(-i_a) : t_word'(i_a);
    assign b_mag = i_b[OPW-1] ? t_word'(-i_b) : t_word'(i_b);

    always_ff @(posedge i_clk) begin
        r_prod <= {{WORD_W{1'b0}}, a_mag} * {{WORD_W{1'b0}}, b_mag};
        r_neg  <= i_a[OPW-1] ^ i_b[OPW-1];
    end

    assign res_pos = $signed({1'b0, r_prod[2*WORD_W-1:FRAC_BITS]});
    assign o_res   = r_neg ? -res_pos : res_pos;

endmodule

[design/cvkt_div.sv]
// Bit-serial restoring divider for the gain quotients, one quotient bit a cycle.
`timescale 1ns / 1ps

module cvkt_div import cvkt_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  t_word                         i_num,
    input  logic [DEN_W-1:0]              i_den,
    output logic                          o_done,
    output logic [WORD_W+FRAC_BITS-1:0]   o_quot
);

    localparam int NW = WORD_W + FRAC_BITS;
    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0]    r_num;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [CW-1:0]    r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             fits;

    assign trial = {r_rem, r_num[NW-1]};
    assign diff  = trial - {1'b0, r_den};
    assign fits  = trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_num  <= {i_num, {FRAC_BITS{1'b0}}};
                r_rem  <= '0;
                r_den  <= i_den;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
                r_num <= {r_num[NW-2:0], fits};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(NW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_num;

endmodule

[design/constant_velocity_kalman_tracker.sv]
// Top level: 3D constant-velocity Kalman tracker sequencer and state.
// Sequence: the first item after reset only seeds the state; later items run two
// bit-serial gain divisions (skipped when Ppred + R is zero) before the updates.
// Throughput: one item at a time; the next is accepted once the result is queued.
// Reset: synchronous active low; clears position and velocity, unseeded, count zero, noise and covariance defaults.
`timescale 1ns / 1ps

module constant_velocity_kalman_tracker import cvkt_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    cvkt_meas_if.sink             i_meas,
    cvkt_est_if.source            o_est,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  t_word                 i_cfg_data
);

    localparam int PW = 65 - FRAC_BITS;
    localparam int NW = WORD_W + FRAC_BITS;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_PRED = 3'd1;
    localparam logic [2:0] ST_DIV0 = 3'd2;
    localparam logic [2:0] ST_DIV1 = 3'd3;
    localparam logic [2:0] ST_AXIS = 3'd4;
    localparam logic [2:0] ST_COV  = 3'd5;
    localparam logic [2:0] ST_OUT  = 3'd6;

    logic [2:0]       r_state;
    logic [2:0]       r_step;
    logic [AX_W-1:0]  r_ax;

    t_word            r_q;
    t_word            r_r;
    t_word            r_iec;

    t_sword           r_pos [AXES];
    t_sword           r_vel [AXES];
    t_word            r_pp;
    t_sword           r_pv;
    t_word            r_vv;
    t_word            r_last;
    logic             r_seeded;
    logic [CNT_W-1:0] r_count;

    t_sword           r_meas [AXES];
    t_sword           meas_in [AXES];
    t_word            r_ts;
    t_word            r_dt;
    t_word            r_dt2;
    t_acc             r_acc;
    t_word            r_ppp;
    t_sword           r_pvp;
    t_word            r_vvp;
    t_word            r_k0;
    t_sword           r_k1;
    t_sword           r_xp;
    t_err             r_e;
    t_err             e_c;

    logic             r_ov;
    t_sword           r_est [AXES];
    logic [CNT_W-1:0] r_est_cnt;

    t_opnd                 mul_a;
    t_opnd                 mul_b;
    logic signed [PW-1:0]  mul_res;
    t_acc                  mr;

    logic                  div_start;
    t_word                 div_num;
    logic [DEN_W-1:0]      s_sum;
    logic                  div_done;
    logic [NW-1:0]         div_quot;
    t_acc                  q_acc;
    t_word                 pvp_mag;

    logic                  in_acc;
    logic                  out_load;

    assign meas_in[0] = i_meas.meas_x;
    assign meas_in[1] = i_meas.meas_y;
    assign meas_in[2] = i_meas.meas_z;

    assign i_meas.ready = (r_state == ST_IDLE);
    assign in_acc       = i_meas.valid && (r_state == ST_IDLE);
    assign out_load     = (r_state == ST_OUT) && (!r_ov || o_est.ready);

    assign mr      = t_acc'({{(ACC_W-PW){mul_res[PW-1]}}, mul_res});
    assign e_c     = t_err'({r_meas[r_ax][WORD_W-1], r_meas[r_ax]})
                   - t_err'({r_xp[WORD_W-1], r_xp});
    assign s_sum   = {1'b0, r_ppp} + {1'b0, r_r};
    assign pvp_mag = t_word'(-r_pvp);
    assign div_num = (r_state == ST_PRED) ? r_ppp : (r_pvp[WORD_W-1] ? pvp_mag : r_pvp);
    assign div_start = ((r_state == ST_PRED) && (r_step == 3'd5) && (s_sum != '0))
                     || ((r_state == ST_DIV0) && div_done);
    assign q_acc   = t_acc'({{(ACC_W-NW){1'b0}}, div_quot});

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            ST_PRED: begin
                case (r_step)
                    3'd1: begin
                        mul_a = op_u(r_dt);
                        mul_b = op_u(r_dt);
                    end
                    3'd2: begin
                        mul_a = op_u(r_dt);
                        mul_b = op_s(r_pv);
                    end
                    3'd3: begin
                        mul_a = op_u(r_dt2);
                        mul_b = op_u(r_vv);
                    end
                    3'd4: begin
                        mul_a = op_u(r_dt);
                        mul_b = op_u(r_vv);
                    end
                    default: ;
                endcase
            end
            ST_AXIS: begin
                case (r_step)
                    3'd0: begin
                        mul_a = op_s(r_vel[r_ax]);
                        mul_b = op_u(r_dt);
                    end
                    3'd2: begin
                        mul_a = op_u(r_k0);
                        mul_b = op_e(e_c);
                    end
                    3'd3: begin
                        mul_a = op_s(r_k1);
                        mul_b = op_e(r_e);
                    end
                    default: ;
                endcase
            end
            ST_COV: begin
                case (r_step)
                    3'd0: begin
                        mul_a = op_u(r_k0);
                        mul_b = op_u(r_ppp);
                    end
                    3'd1: begin
                        mul_a = op_u(r_k0);
                        mul_b = op_s(r_pvp);
                    end
                    3'd2: begin
                        mul_a = op_s(r_k1);
                        mul_b = op_s(r_pvp);
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    cvkt_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_res (mul_res)
    );

    cvkt_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (s_sum),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q   <= PROCESS_NOISE_RST;
            r_r   <= MEASUREMENT_NOISE_RST;
            r_iec <= INITIAL_ERROR_COV_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_PROCESS_NOISE:     r_q   <= i_cfg_data;
                CFG_MEASUREMENT_NOISE: r_r   <= i_cfg_data;
                CFG_INITIAL_ERROR_COV: r_iec <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_step   <= '0;
            r_ax     <= '0;
            r_seeded <= 1'b0;
            r_count  <= '0;
            r_last   <= '0;
            r_pp     <= INITIAL_ERROR_COV_RST;
            r_pv     <= '0;
            r_vv     <= INITIAL_ERROR_COV_RST;
            for (int i = 0; i < AXES; i++) begin
                r_pos[i] <= '0;
                r_vel[i] <= '0;
            end
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        if (!r_seeded) begin
                            for (int i = 0; i < AXES; i++) begin
                                r_pos[i] <= meas_in[i];
                                r_vel[i] <= '0;
                            end
                            r_pp     <= r_iec;
                            r_pv     <= '0;
                            r_vv     <= r_iec;
                            r_last   <= i_meas.timestamp;
                            r_seeded <= 1'b1;
                            r_count  <= CNT_W'(1);
                            r_state  <= ST_OUT;
                        end else begin
                            for (int i = 0; i < AXES; i++) begin
                                r_meas[i] <= meas_in[i];
                            end
                            r_ts    <= i_meas.timestamp;
                            r_step  <= '0;
                            r_state <= ST_PRED;
                        end
                    end
                end
                ST_PRED: begin
                    r_step <= r_step + 1'b1;
                    case (r_step)
                        3'd0: begin
                            r_dt   <= r_ts - r_last;
                            r_last <= r_ts;
                            r_vvp  <= sat_u(acc_u(r_vv) + acc_u(r_q));
                        end
                        3'd2: r_dt2 <= sat_u(mr);
                        3'd3: r_acc <= acc_u(r_pp) + acc_u(r_q) + mr + mr;
                        3'd4: r_ppp <= sat_u(r_acc + mr);
                        3'd5: begin
                            r_pvp <= sat_s(acc_s(r_pv) + mr);
                            if (s_sum == '0) begin
                                r_k0    <= '0;
                                r_k1    <= '0;
                                r_ax    <= '0;
                                r_step  <= '0;
                                r_state <= ST_AXIS;
                            end else begin
                                r_state <= ST_DIV0;
                            end
                        end
                        default: ;
                    endcase
                end
                ST_DIV0: begin
                    if (div_done) begin
                        r_k0    <= div_quot[WORD_W-1:0];
                        r_state <= ST_DIV1;
                    end
                end
                ST_DIV1: begin
                    if (div_done) begin
                        r_k1    <= sat_s(r_pvp[WORD_W-1] ? -q_acc : q_acc);
                        r_ax    <= '0;
                        r_step  <= '0;
                        r_state <= ST_AXIS;
                    end
                end
                ST_AXIS: begin
                    r_step <= r_step + 1'b1;
                    case (r_step)
                        3'd1: r_xp <= sat_s(acc_s(r_pos[r_ax]) + mr);
                        3'd2: r_e  <= e_c;
                        3'd3: r_pos[r_ax] <= sat_s(acc_s(r_xp) + mr);
                        3'd4: begin
                            r_vel[r_ax] <= sat_s(acc_s(r_vel[r_ax]) + mr);
                            r_step      <= '0;
                            if (r_ax == AX_W'(AXES - 1)) begin
                                r_state <= ST_COV;
                            end else begin
                                r_ax <= r_ax + 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
                ST_COV: begin
                    r_step <= r_step + 1'b1;
                    case (r_step)
                        3'd1: r_pp <= sat_u(acc_u(r_ppp) - mr);
                        3'd2: r_pv <= sat_s(acc_s(r_pvp) - mr);
                        3'd3: begin
                            r_vv <= sat_u(acc_u(r_vvp) - mr);
                            if (r_count != '1) begin
                                r_count <= r_count + 1'b1;
                            end
                            r_state <= ST_OUT;
                        end
                        default: ;
                    endcase
                end
                ST_OUT: begin
                    if (out_load) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (out_load) begin
            r_ov <= 1'b1;
        end else if (o_est.ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            for (int i = 0; i < AXES; i++) begin
                r_est[i] <= r_pos[i];
            end
            r_est_cnt <= r_count;
        end
    end

    assign o_est.valid           = r_ov;
    assign o_est.est_x           = r_est[0];
    assign o_est.est_y           = r_est[1];
    assign o_est.est_z           = r_est[2];
    assign o_est.detection_count = r_est_cnt;

    a_seed_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && !r_seeded) |=> (r_state == ST_OUT && r_seeded))
        else $error("seeding transaction did not go straight to output");

    a_k0_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV0 && div_done) |-> (div_quot <= (NW'(1) << FRAC_BITS)))
        else $error("position gain above one");

    a_count_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(r_seeded) |-> (r_count >= $past(r_count)))
        else $error("detection count decreased");

    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_AXIS || r_state == ST_COV) |-> !div_start)
        else $error("divider started outside gain computation");

endmodule
